FILE: design/difficulty_to_target_core_assert.svh
// assertion macros for the difficulty to target core
// used by difficulty_to_target_core, no other dependencies
`ifndef DIFFICULTY_TO_TARGET_CORE_ASSERT_SVH
`define DIFFICULTY_TO_TARGET_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtt assertion failed");

// next-cycle implication, disabled during reset
`define DTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtt assertion failed");

`endif

FILE: design/dtt_pkg.sv
// shared types and constants for the difficulty to target core
// no dependencies
`default_nettype none

package dtt_pkg;

    localparam int TARGET_BITS  = 256;
    localparam int EFF_BITS     = (TARGET_BITS < 64) ? 64 :
                                  ((TARGET_BITS > 512) ? 512 : TARGET_BITS);
    localparam int WORD_BITS    = 64;
    localparam int OUT_WORDS    = 4;
    localparam int QUOT_BITS    = OUT_WORDS * WORD_BITS;
    localparam int STEP_W       = $clog2(EFF_BITS + 1);
    localparam int WIDX_W       = $clog2(OUT_WORDS);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctrl;

endpackage

`default_nettype wire

FILE: design/difficulty_to_target_core.sv
// the difficulty is taken in idle, then come EFF_BITS (256) division steps, then four
// words one per cycle while the output is not stalled
// rate is set by the single 65-bit subtract/compare that makes one quotient bit a cycle
// input is stalled from acceptance until the fourth word is taken
// synchronous active-low reset returns the sequencer to idle with no word pending
// depends on dtt_pkg, dtt_div_unit, dtt_quot_reg and the assertion header
`default_nettype none

module difficulty_to_target_core import dtt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_word i_difficulty,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_word     o_target_word,
    output logic      o_last_word
);

    `include "difficulty_to_target_core_assert.svh"

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step_cnt;
    logic [STEP_W-1:0]   n_step_cnt;
    logic [WIDX_W-1:0]   r_word_idx;
    logic [WIDX_W-1:0]   n_word_idx;
    t_div_ctrl           ctrl;
    logic                qbit;
    logic                in_acc;
    logic                out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step_cnt <= '0;
            r_word_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
            r_word_idx <= n_word_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        n_word_idx = r_word_idx;
        ctrl       = '0;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        in_acc     = 1'b0;
        out_acc    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                in_acc  = i_valid;
                if (in_acc) begin
                    ctrl.start = 1'b1;
                    n_step_cnt = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                ctrl.step  = 1'b1;
                n_step_cnt = r_step_cnt + 1'b1;
                if (r_step_cnt == STEP_W'(EFF_BITS - 1)) begin
                    n_word_idx = '0;
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                out_acc = ~i_stall;
                if (out_acc) begin
                    n_word_idx = r_word_idx + 1'b1;
                    if (o_last_word) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_last_word = (r_word_idx == WIDX_W'(OUT_WORDS - 1));

    dtt_div_unit u_div (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_difficulty (i_difficulty),
        .o_qbit       (qbit)
    );

    dtt_quot_reg u_quot (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_qbit     (qbit),
        .i_word_idx (r_word_idx),
        .o_word     (o_target_word)
    );

    // checks
    `DTT_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall)
    `DTT_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_acc,
        (r_state == ST_DIV) && (r_step_cnt == '0))
    `DTT_ASSERT_NEXT(a_div_done_first_word, i_clk, i_rst_n,
        (r_state == ST_DIV) && (r_step_cnt == STEP_W'(EFF_BITS - 1)),
        o_valid && (r_word_idx == '0))
    `DTT_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, out_acc && o_last_word,
        !o_valid && !o_stall)

endmodule

`default_nettype wire

FILE: design/dtt_div_unit.sv
// restoring divider datapath: one quotient bit per step, all-ones dividend
// depends on dtt_pkg
`default_nettype none

module dtt_div_unit import dtt_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_div_ctrl i_ctrl,
    input  wire t_word     i_difficulty,
    output logic           o_qbit
);

    t_word                r_rem;
    t_word                n_rem;
    t_word                r_divisor;
    t_word                n_divisor;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;

    always_comb begin
        shifted   = {r_rem, 1'b1};
        diff      = shifted - {1'b0, r_divisor};
        o_qbit    = ~diff[WORD_BITS];
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_ctrl.start) begin
            n_rem     = '0;
            n_divisor = (i_difficulty == '0) ? t_word'(1) : i_difficulty;
        end else if (i_ctrl.step) begin
            n_rem = o_qbit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

endmodule

`default_nettype wire

FILE: design/dtt_quot_reg.sv
// quotient shift register with overflow saturation and word select
// depends on dtt_pkg
`default_nettype none

module dtt_quot_reg import dtt_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_div_ctrl         i_ctrl,
    input  wire logic              i_qbit,
    input  wire logic [WIDX_W-1:0] i_word_idx,
    output t_word                  o_word
);

    logic [QUOT_BITS-1:0] r_quot;
    logic [QUOT_BITS-1:0] n_quot;
    logic                 r_ovf;
    logic                 n_ovf;
    t_word                words [OUT_WORDS];

    always_comb begin
        n_quot = r_quot;
        n_ovf  = r_ovf;
        if (i_ctrl.start) begin
            n_quot = '0;
            n_ovf  = 1'b0;
        end else if (i_ctrl.step) begin
            n_quot = {r_quot[QUOT_BITS-2:0], i_qbit};
            n_ovf  = r_ovf | r_quot[QUOT_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_ovf  <= n_ovf;
    end

    always_comb begin
        for (int i = 0; i < OUT_WORDS; i++) begin
            words[i] = r_quot[QUOT_BITS-1-i*WORD_BITS -: WORD_BITS];
        end
        o_word = r_ovf ? '1 : words[i_word_idx];
    end

endmodule

`default_nettype wire

FILE: sim/difficulty_to_target_core_tb.sv
// testbench for difficulty_to_target_core: sends difficulties, predicts the 256-bit share target
// by bit-serial long division of the all-ones dividend and checks each target word in order
// depends on dtt_pkg and difficulty_to_target_core
`timescale 1ns / 100ps
`default_nettype none

module difficulty_to_target_core_tb;
    import dtt_pkg::*;

    typedef struct packed {
        t_word word;
        logic  last;
    } t_target_word;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_valid      = 1'b0;
    t_word i_difficulty = '0;
    logic  i_stall      = 1'b0;
    wire   o_stall;
    wire   o_valid;
    t_word o_target_word;
    wire   o_last_word;

    logic idling_on = 1'b1;
    int   stall_left = 0;
    int   difficulties_sent = 0;
    int   words_checked = 0;
    int   mismatch_count = 0;

    // predictor state
    t_word                  held_divisor = '0;
    logic [WORD_BITS:0]     running_rem = '0;
    logic [QUOT_BITS-1:0]   target_quot = '0;
    int                     bit_count = 0;
    t_target_word           target_words_due[$];
    t_target_word           word_due;

    difficulty_to_target_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_difficulty  (i_difficulty),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_target_word (o_target_word),
        .o_last_word   (o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic predict_target(input t_word difficulty);
        logic         saturated;
        t_target_word due_entry;
        saturated = 1'b0;
        held_divisor = (difficulty == '0) ? t_word'(1) : difficulty;
        running_rem = '0;
        target_quot = '0;
        bit_count = 0;
        for (int n = 0; n < EFF_BITS; n++) begin
            running_rem = {running_rem[WORD_BITS-1:0], 1'b1};
            saturated |= target_quot[QUOT_BITS-1];
            target_quot = target_quot << 1;
            if (running_rem >= {1'b0, held_divisor}) begin
                running_rem = running_rem - {1'b0, held_divisor};
                target_quot[0] = 1'b1;
            end
            bit_count++;
        end
        if (saturated)
            target_quot = '1;
        for (int w = 0; w < OUT_WORDS; w++) begin
            due_entry.word = target_quot[QUOT_BITS-1-w*WORD_BITS -: WORD_BITS];
            due_entry.last = (w == OUT_WORDS - 1);
            target_words_due = {target_words_due, due_entry};
        end
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("error at %0t ns: %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic send_difficulty(input t_word difficulty);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_difficulty <= difficulty;
        do @(posedge i_clk); while (o_stall);
        predict_target(difficulty);
        difficulties_sent++;
    endtask

    task automatic drain_targets();
        i_valid <= 1'b0;
        while (target_words_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_word random_difficulty();
        t_word d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: d = d >> $urandom_range(0, 63);
            1: d = t_word'($urandom_range(0, 20));
            default: ;
        endcase
        return d;
    endfunction

    // zero, one, all ones and values around the word boundaries
    task automatic test_edge_difficulties();
        t_word edges[$];
        edges = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd10, 64'd1000, 64'h1_0001,
                  64'hFFFF_FFFF, 64'h1_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
        foreach (edges[k])
            send_difficulty(edges[k]);
        drain_targets();
    endtask

    task automatic test_random_difficulties(input int count);
        repeat (count)
            send_difficulty(random_difficulty());
        drain_targets();
    endtask

    task automatic test_random_full_rate(input int count);
        repeat (count)
            send_difficulty(random_difficulty());
        drain_targets();
    endtask

    // output stall in random bursts while idling is on, with the stall released between bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && !i_stall && idling_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 12);
        i_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left = stall_left - 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (target_words_due.size() == 0) begin
                report_mismatch("target word with nothing due", o_target_word, '0);
            end else begin
                word_due = target_words_due.pop_front();
                if (o_target_word !== word_due.word)
                    report_mismatch("target word", o_target_word, word_due.word);
                if (o_last_word !== word_due.last)
                    report_mismatch("last word flag", t_word'(o_last_word), t_word'(word_due.last));
            end
            words_checked++;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_difficulties();
        test_random_difficulties(95);
        idling_on <= 1'b0;
        @(posedge i_clk);
        test_random_full_rate(40);
        repeat (300) @(posedge i_clk);
        $display("sent %0d difficulties (edge values, random with stalls, back to back)",
                 difficulties_sent);
        $display("checked %0d target words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0 && target_words_due.size() == 0)
            $display("difficulty_to_target_core: match");
        else
            $display("difficulty_to_target_core: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("difficulty_to_target_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/dtt_pkg.sv
design/dtt_div_unit.sv
design/dtt_quot_reg.sv
design/difficulty_to_target_core.sv
sim/difficulty_to_target_core_tb.sv
